/* design/sctag_pkg.sv */
// ----------------------------------------------------------------------------
// sctag_pkg : sector cache tag engine package
// Item types, command codes, action codes and controller states shared by
// the tag engine.
// ----------------------------------------------------------------------------
package sctag_pkg;

    // Request commands
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Result actions
    localparam logic [2:0] ACT_BYPASS_BIG  = 3'd0;
    localparam logic [2:0] ACT_BYPASS_END  = 3'd1;
    localparam logic [2:0] ACT_HIT         = 3'd2;
    localparam logic [2:0] ACT_FILL_FREE   = 3'd3;
    localparam logic [2:0] ACT_FILL_RROBIN = 3'd4;
    localparam logic [2:0] ACT_WRITE       = 3'd5;
    localparam logic [2:0] ACT_CLEARED     = 3'd6;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] sector;
        logic [15:0] sector_count;
        logic        fill_ok;
    } t_req;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  block_index;
        logic [3:0]  hit_offset;
        logic        fill_committed;
        logic [3:0]  invalidated_mask;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] write_total;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

endpackage

/* design/sector_cache_tag_engine.sv */
// ----------------------------------------------------------------------------
// sector_cache_tag_engine : tag and policy engine of a sector cache
// Fully associative block tags held in a synchronous tag memory, scanned one
// entry per cycle; round-robin victim choice, write invalidation, statistics.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+--------------------------
//  request   | in        | i_req_valid / o_req_stall | i_req  (sctag_pkg::t_req)
//  result    | out       | o_rsp_valid / i_rsp_stall | o_rsp  (sctag_pkg::t_rsp)
//  config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (disk_sectors)
//
//  A read that bypasses, or a clear, goes from the accept straight to the result.
//  A cached read or a write scans the tag memory first: the tag memory has
//  one read port, so the scan reads one block start per cycle, then waits
//  for the registered read data and commits the result.
//  Reset (synchronous, active low) empties every block through the valid
//  flags at once, zeroes the victim pointer, the counters and disk_sectors.
//  A stalled result waits in the output register; the next item is accepted
//  meanwhile and holds in its commit cycle until the register is free.
//
module sector_cache_tag_engine #(
    parameter int NUM_BLOCKS        = 4,
    parameter int SECTORS_PER_BLOCK = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  sctag_pkg::t_req   i_req,
    // result channel
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output sctag_pkg::t_rsp   o_rsp,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [31:0]       i_cfg_data
);

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam logic [32:0] SPB33 = 33'(SECTORS_PER_BLOCK);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BLOCKS - 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(NUM_BLOCKS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    sctag_pkg::t_state r_state, n_state;
    sctag_pkg::t_req   r_req;
    sctag_pkg::t_rsp   r_rsp, n_rsp;
    logic              r_rsp_valid, n_rsp_valid;

    logic [31:0]           r_disk_sectors;
    logic [NUM_BLOCKS-1:0] r_valid, n_valid;
    logic [IW-1:0]         r_ptr, n_ptr;
    logic [31:0]           r_hits, n_hits;
    logic [31:0]           r_misses, n_misses;
    logic [31:0]           r_writes, n_writes;

    // scan
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [31:0]           r_rd_data;
    logic                  r_rd_live;
    logic [IW-1:0]         r_rd_idx;

    // scan accumulators
    logic                  r_hit_found;
    logic [IW-1:0]         r_hit_idx;
    logic [3:0]            r_hit_off;
    logic                  r_empty_found;
    logic [IW-1:0]         r_empty_idx;
    logic [NUM_BLOCKS-1:0] r_mask;

    // tag memory: start sector of each block; end is start + SECTORS_PER_BLOCK
    logic [31:0]           r_start_mem [NUM_BLOCKS];
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic req_take;
    logic out_free;

    assign o_req_stall = (r_state != sctag_pkg::S_IDLE);
    assign req_take    = i_req_valid && !o_req_stall;
    assign out_free    = !r_rsp_valid || !i_rsp_stall;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Bypass tests, evaluated on the request in hand
    // ------------------------------------------------------------------
    function automatic logic is_big(input logic [15:0] cnt);
        return 32'(cnt) > 32'(SECTORS_PER_BLOCK);
    endfunction

    function automatic logic is_near_end(input logic [31:0] sec, input logic [31:0] disk);
        return ({1'b0, sec} + SPB33) >= {1'b0, disk};
    endfunction

    // ------------------------------------------------------------------
    // Compare stage: one block start arrives per cycle from the memory
    // ------------------------------------------------------------------
    logic [32:0] cmp_start, cmp_end, cmp_sec, cmp_last;
    logic        cmp_vld, cmp_hit, cmp_ovl;
    logic [31:0] cmp_diff;

    always_comb begin
        cmp_start = {1'b0, r_rd_data};
        cmp_end   = cmp_start + SPB33;
        cmp_sec   = {1'b0, r_req.sector};
        cmp_last  = cmp_sec + 33'(r_req.sector_count);
        cmp_vld   = r_valid[r_rd_idx];
        cmp_hit   = cmp_vld && (cmp_sec >= cmp_start) && (cmp_last <= cmp_end);
        cmp_ovl   = cmp_vld && (cmp_sec < cmp_end) && (cmp_last > cmp_start);
        cmp_diff  = r_req.sector - r_rd_data;
    end

    // ------------------------------------------------------------------
    // Control: next state, commit of the result and of the state updates
    // ------------------------------------------------------------------
    logic [IW-1:0] ptr_inc;
    logic [IW-1:0] res_idx;
    logic [31:0]   res_idx_ext;
    logic [63:0]   mask_ext;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        n_valid     = r_valid;
        n_ptr       = r_ptr;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_writes    = r_writes;
        rd_en       = 1'b0;
        rd_addr     = r_cnt[IW-1:0];
        mem_we      = 1'b0;
        mem_waddr   = r_empty_idx;
        ptr_inc     = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
        res_idx     = '0;
        res_idx_ext = '0;
        mask_ext    = 64'(r_mask);

        // drop the result once taken
        if (r_rsp_valid && !i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            sctag_pkg::S_IDLE: begin
                if (req_take) begin
                    n_cnt = '0;
                    case (i_req.command)
                        sctag_pkg::CMD_READ: begin
                            if (is_big(i_req.sector_count) ||
                                is_near_end(i_req.sector, r_disk_sectors)) begin
                                n_state = sctag_pkg::S_DONE;
                            end else begin
                                n_state = sctag_pkg::S_SCAN;
                            end
                        end
                        sctag_pkg::CMD_WRITE: begin
                            n_state = sctag_pkg::S_SCAN;
                        end
                        sctag_pkg::CMD_CLEAR: begin
                            n_state = sctag_pkg::S_DONE;
                        end
                        default: begin
                            n_state = sctag_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            sctag_pkg::S_SCAN: begin
                rd_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    n_state = sctag_pkg::S_LAST;
                end
            end
            sctag_pkg::S_LAST: begin
                // last block start is compared in this cycle
                n_state = sctag_pkg::S_DONE;
            end
            sctag_pkg::S_DONE: begin
                if (out_free) begin
                    n_state                = sctag_pkg::S_IDLE;
                    n_rsp_valid            = 1'b1;
                    n_rsp.action           = sctag_pkg::ACT_CLEARED;
                    n_rsp.hit_offset       = '0;
                    n_rsp.fill_committed   = 1'b0;
                    n_rsp.invalidated_mask = '0;
                    case (r_req.command)
                        sctag_pkg::CMD_CLEAR: begin
                            n_valid  = '0;
                            n_ptr    = '0;
                            n_hits   = '0;
                            n_misses = '0;
                            n_writes = '0;
                        end
                        sctag_pkg::CMD_WRITE: begin
                            n_writes               = r_writes + 1'b1;
                            n_valid                = r_valid & ~r_mask;
                            n_rsp.action           = sctag_pkg::ACT_WRITE;
                            n_rsp.invalidated_mask = mask_ext[3:0];
                        end
                        default: begin
                            if (is_big(r_req.sector_count)) begin
                                n_rsp.action = sctag_pkg::ACT_BYPASS_BIG;
                            end else if (is_near_end(r_req.sector, r_disk_sectors)) begin
                                n_rsp.action = sctag_pkg::ACT_BYPASS_END;
                            end else if (r_hit_found) begin
                                n_hits           = r_hits + 1'b1;
                                n_rsp.action     = sctag_pkg::ACT_HIT;
                                n_rsp.hit_offset = r_hit_off;
                                res_idx          = r_hit_idx;
                            end else begin
                                n_misses             = r_misses + 1'b1;
                                n_rsp.fill_committed = r_req.fill_ok;
                                if (r_empty_found) begin
                                    n_rsp.action = sctag_pkg::ACT_FILL_FREE;
                                    res_idx      = r_empty_idx;
                                end else begin
                                    n_rsp.action = sctag_pkg::ACT_FILL_RROBIN;
                                    n_ptr        = ptr_inc;
                                    res_idx      = ptr_inc;
                                end
                                // commit the fill only on a good device read
                                if (r_req.fill_ok) begin
                                    mem_we           = 1'b1;
                                    mem_waddr        = res_idx;
                                    n_valid[res_idx] = 1'b1;
                                end
                            end
                        end
                    endcase
                    n_rsp.hit_total   = n_hits;
                    n_rsp.miss_total  = n_misses;
                    n_rsp.write_total = n_writes;
                    res_idx_ext       = 32'(res_idx);
                    n_rsp.block_index = res_idx_ext[1:0];
                end
            end
            default: begin
                n_state = sctag_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= sctag_pkg::S_IDLE;
            r_rsp_valid    <= 1'b0;
            r_valid        <= '0;
            r_ptr          <= '0;
            r_hits         <= '0;
            r_misses       <= '0;
            r_writes       <= '0;
            r_cnt          <= '0;
            r_rd_live      <= 1'b0;
            r_disk_sectors <= '0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            r_valid     <= n_valid;
            r_ptr       <= n_ptr;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_writes    <= n_writes;
            r_cnt       <= n_cnt;
            r_rd_live   <= rd_en;
            if (i_cfg_valid && o_cfg_ready) begin
                r_disk_sectors <= i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: request, result, scan accumulators
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_rsp    <= n_rsp;
        r_rd_idx <= rd_addr;
        if (req_take) begin
            r_req         <= i_req;
            r_hit_found   <= 1'b0;
            r_empty_found <= 1'b0;
            r_mask        <= '0;
        end else if (r_rd_live) begin
            // keep the first covering block and the first empty one
            if (cmp_hit && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_rd_idx;
                r_hit_off   <= cmp_diff[3:0];
            end
            if (!cmp_vld && !r_empty_found) begin
                r_empty_found <= 1'b1;
                r_empty_idx   <= r_rd_idx;
            end
            if (cmp_ovl) begin
                r_mask[r_rd_idx] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tag memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_start_mem[mem_waddr] <= r_req.sector;
        end
        if (rd_en) begin
            r_rd_data <= r_start_mem[rd_addr];
        end
    end

endmodule
